### hdl/lpab_pkg.sv
// Shared types and constants for the length-prefixed to Annex-B converter.
// Depends on nothing; used by the converter top level.
package lpab_pkg;

    // Status codes carried on the closing result of a unit
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TRUNC = 2'd1,
        ST_LEN   = 2'd2,
        ST_HDR   = 2'd3
    } status_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NAL_LENGTH_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODEC_IS_HEVC    = 2'd1;

    localparam logic [CFG_DATA_W-1:0] NAL_LENGTH_BYTES_RST = 3'd4;

    // NAL length counter and saturation
    localparam int NAL_LEFT_W = 32;
    localparam logic [NAL_LEFT_W-1:0] NAL_LEFT_MAX   = 32'hFFFF_FFFF;
    localparam logic [NAL_LEFT_W-1:0] NAL_SHIFT_LIM  = 32'h00FF_FFFF;

    // Start code 00 00 00 01
    localparam int SC_CNT_W = 3;
    localparam logic [SC_CNT_W-1:0] START_CODE_LEN = 3'd4;
    localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
    localparam logic [7:0] SC_LAST_BYTE = 8'h01;

    // NAL header fields
    localparam logic [7:0] FORBIDDEN_MASK = 8'h80;
    localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
    localparam logic [7:0] H264_TYPE_MAX  = 8'd23;
    localparam logic [7:0] HEVC_TYPE_MASK = 8'h3F;
    localparam logic [7:0] HEVC_TYPE_MAX  = 8'd47;
    localparam logic [7:0] HEVC_TID_MASK  = 8'h07;

    // One stored result word
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       unit_end;
        status_t    status;
    } res_t;

endpackage

### hdl/length_prefixed_to_annexb_converter.sv
// Length-prefixed (AVCC style) to Annex-B NAL stream converter, top level.
// Depends on lpab_pkg for status codes, register indexes and header constants.
// Single module: input register, one step of decode logic, result register.

// Takes one access-unit byte per word on the input channel and produces Annex-B
// words on the output channel, each byte passing the input register and then
// the result register. Length-field and body bytes move at one word per cycle
// while out_ready holds; the first byte of each NAL produces five output words
// (00 00 00 01 and the byte itself), so the output port sets the rate there:
// the byte holds the result register until all five leave; input stalls behind it.
// On the first error (truncated length field, zero length or overrun, bad
// header) nothing more is emitted for the unit; input is dropped up to the
// byte flagged unit_last, which yields one status word with byte_valid low,
// unit_end high and the error code. A good unit ends with unit_end high on
// its last NAL byte. Configuration is taken at any time (cfg_ready is always
// high) but should only be written while the block is idle.
module length_prefixed_to_annexb_converter #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lpab_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpab_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            unit_last,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            byte_valid,
    output logic                            unit_end,
    output logic [1:0]                      status
);

    // length field counter must hold the largest field size
    localparam int SEEN_W = $clog2(MAX_LENGTH_BYTES + 1);

    typedef enum logic [1:0] {
        PH_LEN,
        PH_FIRST,
        PH_SECOND,
        PH_BODY
    } phase_t;

    // configuration
    logic [lpab_pkg::CFG_DATA_W-1:0] len_cfg_reg;
    logic                            hevc_reg;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parse state
    phase_t                          phase_reg, phase_next;
    logic [SEEN_W-1:0]               seen_reg, seen_next;
    logic [lpab_pkg::NAL_LEFT_W-1:0] left_reg, left_next;
    lpab_pkg::status_t               err_reg, err_next;
    logic                            disc_reg, disc_next;

    // result register: one stored word plus pending start-code bytes ahead of it
    logic                           pend_reg, pend_next;
    logic [lpab_pkg::SC_CNT_W-1:0]  sc_cnt_reg, sc_cnt_next;
    lpab_pkg::res_t                 res_reg, res_next;

    // step outputs
    logic                           st_has_res;
    logic [lpab_pkg::SC_CNT_W-1:0]  st_sc;
    lpab_pkg::res_t                 st_res;

    logic res_free;
    logic proc_fire;
    logic out_fire;
    logic [SEEN_W-1:0] eff_len;

    //------------------------------------------------------------------
    // handshakes
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign out_valid = pend_reg;
    assign out_fire  = pend_reg & out_ready;
    // result register frees up once its last word leaves this cycle
    assign res_free  = ~pend_reg | ((sc_cnt_reg == '0) & out_ready);
    assign proc_fire = in_vld_reg & res_free;
    assign in_ready  = ~in_vld_reg | proc_fire;

    // effective length field size: 0 acts as 1, clamp to the maximum
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            eff_len = SEEN_W'(1);
        end
        else if (32'(len_cfg_reg) > MAX_LENGTH_BYTES)
        begin
            eff_len = SEEN_W'(MAX_LENGTH_BYTES);
        end
        else
        begin
            eff_len = SEEN_W'(len_cfg_reg);
        end
    end

    //------------------------------------------------------------------
    // one parse step on the registered input byte
    //------------------------------------------------------------------
    always_comb
    begin
        logic                            fail_hit;
        lpab_pkg::status_t               fail_code;
        logic                            body_hit;
        logic                            hdr_ok;
        logic [SEEN_W-1:0]               seen_inc;
        logic [lpab_pkg::NAL_LEFT_W-1:0] len_shift;
        logic [lpab_pkg::NAL_LEFT_W-1:0] left_dec;
        logic [7:0]                      hevc_type;
        logic [7:0]                      avc_type;
        logic                            forbidden;
        logic                            overrun;

        phase_next = phase_reg;
        seen_next  = seen_reg;
        left_next  = left_reg;
        err_next   = err_reg;
        disc_next  = disc_reg;

        st_has_res        = 1'b0;
        st_sc             = '0;
        st_res.data       = in_byte_reg;
        st_res.byte_valid = 1'b1;
        st_res.unit_end   = 1'b0;
        st_res.status     = lpab_pkg::ST_OK;

        fail_hit  = 1'b0;
        fail_code = lpab_pkg::ST_OK;
        body_hit  = 1'b0;
        hdr_ok    = 1'b0;

        seen_inc  = seen_reg + SEEN_W'(1);
        len_shift = (left_reg > lpab_pkg::NAL_SHIFT_LIM) ? lpab_pkg::NAL_LEFT_MAX
                                                        : {left_reg[23:0], in_byte_reg};
        left_dec  = left_reg - lpab_pkg::NAL_LEFT_W'(1);
        hevc_type = (in_byte_reg >> 1) & lpab_pkg::HEVC_TYPE_MASK;
        avc_type  = in_byte_reg & lpab_pkg::H264_TYPE_MASK;
        forbidden = (in_byte_reg & lpab_pkg::FORBIDDEN_MASK) != 8'h00;
        // NAL would still need bytes past the unit's last byte
        overrun   = in_last_reg & (left_reg > lpab_pkg::NAL_LEFT_W'(1));

        if (disc_reg)
        begin
            if (in_last_reg)
            begin
                st_has_res        = 1'b1;
                st_res.data       = 8'h00;
                st_res.byte_valid = 1'b0;
                st_res.unit_end   = 1'b1;
                st_res.status     = err_reg;
                phase_next = PH_LEN;
                seen_next  = '0;
                left_next  = '0;
                err_next   = lpab_pkg::ST_OK;
                disc_next  = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    left_next = len_shift;
                    if (seen_inc >= eff_len)
                    begin
                        seen_next = '0;
                        if ((len_shift == '0) || in_last_reg)
                        begin
                            fail_hit  = 1'b1;
                            fail_code = lpab_pkg::ST_LEN;
                        end
                        else
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                    else
                    begin
                        seen_next = seen_inc;
                        if (in_last_reg)
                        begin
                            fail_hit  = 1'b1;
                            fail_code = lpab_pkg::ST_TRUNC;
                        end
                    end
                end
                PH_FIRST:
                begin
                    if (hevc_reg)
                    begin
                        hdr_ok = ~forbidden && (hevc_type <= lpab_pkg::HEVC_TYPE_MAX)
                              && (left_reg >= lpab_pkg::NAL_LEFT_W'(2));
                    end
                    else
                    begin
                        hdr_ok = ~forbidden && (avc_type != 8'h00)
                              && (avc_type <= lpab_pkg::H264_TYPE_MAX);
                    end
                    if (overrun)
                    begin
                        fail_hit  = 1'b1;
                        fail_code = lpab_pkg::ST_LEN;
                    end
                    else if (!hdr_ok)
                    begin
                        fail_hit  = 1'b1;
                        fail_code = lpab_pkg::ST_HDR;
                    end
                    else
                    begin
                        body_hit   = 1'b1;
                        st_sc      = lpab_pkg::START_CODE_LEN;
                        phase_next = hevc_reg ? PH_SECOND : PH_BODY;
                    end
                end
                PH_SECOND:
                begin
                    if (overrun)
                    begin
                        fail_hit  = 1'b1;
                        fail_code = lpab_pkg::ST_LEN;
                    end
                    else if ((in_byte_reg & lpab_pkg::HEVC_TID_MASK) == 8'h00)
                    begin
                        fail_hit  = 1'b1;
                        fail_code = lpab_pkg::ST_HDR;
                    end
                    else
                    begin
                        body_hit   = 1'b1;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (overrun)
                    begin
                        fail_hit  = 1'b1;
                        fail_code = lpab_pkg::ST_LEN;
                    end
                    else
                    begin
                        body_hit = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_LEN;
                end
            endcase

            if (body_hit)
            begin
                st_has_res = 1'b1;
                left_next  = left_dec;
                if (left_dec == '0)
                begin
                    if (in_last_reg)
                    begin
                        // good end of unit
                        st_res.unit_end = 1'b1;
                        phase_next = PH_LEN;
                        seen_next  = '0;
                        left_next  = '0;
                        err_next   = lpab_pkg::ST_OK;
                        disc_next  = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
            end

            if (fail_hit)
            begin
                if (in_last_reg)
                begin
                    // error on the last byte closes the unit at once
                    st_has_res        = 1'b1;
                    st_sc             = '0;
                    st_res.data       = 8'h00;
                    st_res.byte_valid = 1'b0;
                    st_res.unit_end   = 1'b1;
                    st_res.status     = fail_code;
                    phase_next = PH_LEN;
                    seen_next  = '0;
                    left_next  = '0;
                    err_next   = lpab_pkg::ST_OK;
                    disc_next  = 1'b0;
                end
                else
                begin
                    err_next  = fail_code;
                    disc_next = 1'b1;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // result register next state
    //------------------------------------------------------------------
    always_comb
    begin
        pend_next   = pend_reg;
        sc_cnt_next = sc_cnt_reg;
        res_next    = res_reg;
        if (proc_fire)
        begin
            pend_next   = st_has_res;
            sc_cnt_next = st_sc;
            res_next    = st_res;
        end
        else if (out_fire)
        begin
            if (sc_cnt_reg != '0)
            begin
                sc_cnt_next = sc_cnt_reg - lpab_pkg::SC_CNT_W'(1);
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
    end

    // start-code bytes go out ahead of the stored word
    always_comb
    begin
        if (sc_cnt_reg != '0)
        begin
            out_byte   = (sc_cnt_reg == lpab_pkg::SC_CNT_W'(1)) ? lpab_pkg::SC_LAST_BYTE
                                                                : lpab_pkg::SC_ZERO_BYTE;
            byte_valid = 1'b1;
            unit_end   = 1'b0;
            status     = lpab_pkg::ST_OK;
        end
        else
        begin
            out_byte   = res_reg.data;
            byte_valid = res_reg.byte_valid;
            unit_end   = res_reg.unit_end;
            status     = res_reg.status;
        end
    end

    //------------------------------------------------------------------
    // registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= lpab_pkg::NAL_LENGTH_BYTES_RST;
            hevc_reg    <= 1'b0;
            in_vld_reg  <= 1'b0;
            phase_reg   <= PH_LEN;
            seen_reg    <= '0;
            left_reg    <= '0;
            err_reg     <= lpab_pkg::ST_OK;
            disc_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            sc_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    lpab_pkg::CFG_NAL_LENGTH_BYTES: len_cfg_reg <= cfg_data;
                    lpab_pkg::CFG_CODEC_IS_HEVC:    hevc_reg    <= cfg_data[0];
                    default:                        ;
                endcase
            end
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (proc_fire)
            begin
                phase_reg <= phase_next;
                seen_reg  <= seen_next;
                left_reg  <= left_next;
                err_reg   <= err_next;
                disc_reg  <= disc_next;
            end
            pend_reg   <= pend_next;
            sc_cnt_reg <= sc_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= unit_last;
        end
        res_reg <= res_next;
    end

`ifndef SYNTH
    // start-code bytes only count down ahead of a stored word
    assert property (@(posedge clk) disable iff (!rst_n)
        (sc_cnt_reg != '0) |-> pend_reg)
        else $error("start code pending without result word");

    // a word without a byte always closes the unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> unit_end)
        else $error("status word does not close the unit");

    // error codes only ride on status words
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != lpab_pkg::ST_OK)) |-> (!byte_valid && unit_end))
        else $error("nonzero status on a data word");

    // discard mode always remembers a real error
    assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (err_reg != lpab_pkg::ST_OK))
        else $error("discarding without an error code");

    // inside a NAL there are bytes left to pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_LEN) |-> (left_reg != '0))
        else $error("NAL phase with no bytes left");
`endif

endmodule

### tb/sv/lpab_annexb_checker.sv
// Scoreboard for the length-prefixed to Annex-B converter: tracks the config
// writes, predicts every output word from the accepted input bytes, compares.
// Depends on lpab_pkg for status codes, register indexes and header constants.
`timescale 1ns / 100ps

module lpab_annexb_checker #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [lpab_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpab_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [7:0]                       in_byte,
    input  logic                             unit_last,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [7:0]                       out_byte,
    input  logic                             byte_valid,
    input  logic                             unit_end,
    input  logic [1:0]                       status,
    output int                               fail_count,
    output int                               pending_words,
    output int                               decoded_bytes,
    output int                               words_checked,
    output int                               units_closed,
    output int                               units_dropped
);

    typedef enum logic [1:0] {GATHER_LEN, FIRST_HDR, SECOND_HDR, NAL_BODY} nal_phase_t;

    // shadow registers
    logic [lpab_pkg::CFG_DATA_W-1:0] len_reg;
    logic                            hevc_reg;

    // shadow decode state
    nal_phase_t                      phase;
    logic [2:0]                      len_seen;
    logic [lpab_pkg::NAL_LEFT_W-1:0] nal_left;
    lpab_pkg::status_t               held_status;
    logic                            discarding;

    lpab_pkg::res_t annexb_words[$];
    int             mismatch_total;
    int             decoded_total;
    int             checked_total;
    int             closed_total;
    int             dropped_total;

    task report_mismatch(input string what, input int got, input int want);
        mismatch_total++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    function automatic void push_word(input logic [7:0] data, input logic valid_bit,
                                      input logic end_bit, input lpab_pkg::status_t code);
        lpab_pkg::res_t w;
        w.data       = data;
        w.byte_valid = valid_bit;
        w.unit_end   = end_bit;
        w.status     = code;
        annexb_words.push_back(w);
    endfunction

    function automatic void clear_unit();
        phase       = GATHER_LEN;
        len_seen    = '0;
        nal_left    = '0;
        held_status = lpab_pkg::ST_OK;
        discarding  = 1'b0;
    endfunction

    // error on the last byte closes at once, otherwise drop until unit_last
    function automatic void raise_error(input lpab_pkg::status_t code, input logic last);
        if (last)
        begin
            push_word(8'h00, 1'b0, 1'b1, code);
            clear_unit();
        end
        else
        begin
            held_status = code;
            discarding  = 1'b1;
        end
    endfunction

    function automatic void emit_nal_byte(input logic [7:0] b, input logic last);
        nal_left = nal_left - 1'b1;
        if (nal_left == '0)
        begin
            push_word(b, 1'b1, last, lpab_pkg::ST_OK);
            if (last)
                clear_unit();
            else
                phase = GATHER_LEN;
        end
        else
        begin
            push_word(b, 1'b1, 1'b0, lpab_pkg::ST_OK);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int   eff;
        logic hdr_ok;

        eff = len_reg;
        if (eff < 1)
            eff = 1;
        if (eff > MAX_LENGTH_BYTES)
            eff = MAX_LENGTH_BYTES;

        if (discarding)
        begin
            if (last)
            begin
                push_word(8'h00, 1'b0, 1'b1, held_status);
                clear_unit();
            end
            return;
        end

        case (phase)
            FIRST_HDR:
            begin
                if (last && nal_left > 1)
                begin
                    raise_error(lpab_pkg::ST_LEN, last);
                    return;
                end
                if (hevc_reg)
                    hdr_ok = (b & lpab_pkg::FORBIDDEN_MASK) == 8'h00
                          && ((b >> 1) & lpab_pkg::HEVC_TYPE_MASK) <= lpab_pkg::HEVC_TYPE_MAX
                          && nal_left >= 2;
                else
                    hdr_ok = (b & lpab_pkg::FORBIDDEN_MASK) == 8'h00
                          && (b & lpab_pkg::H264_TYPE_MASK) != 8'h00
                          && (b & lpab_pkg::H264_TYPE_MASK) <= lpab_pkg::H264_TYPE_MAX;
                if (!hdr_ok)
                begin
                    raise_error(lpab_pkg::ST_HDR, last);
                    return;
                end
                repeat (lpab_pkg::START_CODE_LEN - 1)
                    push_word(lpab_pkg::SC_ZERO_BYTE, 1'b1, 1'b0, lpab_pkg::ST_OK);
                push_word(lpab_pkg::SC_LAST_BYTE, 1'b1, 1'b0, lpab_pkg::ST_OK);
                phase = hevc_reg ? SECOND_HDR : NAL_BODY;
                emit_nal_byte(b, last);
            end
            SECOND_HDR:
            begin
                if (last && nal_left > 1)
                    raise_error(lpab_pkg::ST_LEN, last);
                else if ((b & lpab_pkg::HEVC_TID_MASK) == 8'h00)
                    raise_error(lpab_pkg::ST_HDR, last);
                else
                begin
                    phase = NAL_BODY;
                    emit_nal_byte(b, last);
                end
            end
            NAL_BODY:
            begin
                if (last && nal_left > 1)
                    raise_error(lpab_pkg::ST_LEN, last);
                else
                    emit_nal_byte(b, last);
            end
            default:
            begin
                if (nal_left > lpab_pkg::NAL_SHIFT_LIM)
                    nal_left = lpab_pkg::NAL_LEFT_MAX;
                else
                    nal_left = {nal_left[lpab_pkg::NAL_LEFT_W-9:0], b};
                len_seen = len_seen + 3'd1;
                if (len_seen >= eff)
                begin
                    len_seen = '0;
                    if (nal_left == '0 || last)
                        raise_error(lpab_pkg::ST_LEN, last);
                    else
                        phase = FIRST_HDR;
                end
                else if (last)
                begin
                    raise_error(lpab_pkg::ST_TRUNC, last);
                end
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lpab_pkg::res_t want;
        if (!rst_n)
        begin
            len_reg  = lpab_pkg::NAL_LENGTH_BYTES_RST;
            hevc_reg = 1'b0;
            clear_unit();
            annexb_words.delete();
            mismatch_total = 0;
            decoded_total  = 0;
            checked_total  = 0;
            closed_total   = 0;
            dropped_total  = 0;
            fail_count    <= 0;
            pending_words <= 0;
            decoded_bytes <= 0;
            words_checked <= 0;
            units_closed  <= 0;
            units_dropped <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lpab_pkg::CFG_NAL_LENGTH_BYTES: len_reg  = cfg_data;
                    lpab_pkg::CFG_CODEC_IS_HEVC:    hevc_reg = cfg_data[0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                checked_total++;
                if (unit_end)
                    closed_total++;
                if (unit_end && !byte_valid)
                    dropped_total++;
                if (annexb_words.size() == 0)
                begin
                    report_mismatch("word with nothing expected", out_byte, 0);
                end
                else
                begin
                    want = annexb_words.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", out_byte, want.data);
                    if (byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", byte_valid, want.byte_valid);
                    if (unit_end !== want.unit_end)
                        report_mismatch("unit_end", unit_end, want.unit_end);
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                end
            end

            if (in_valid && in_ready)
            begin
                if (!discarding)
                    decoded_total++;
                decode_byte(in_byte, unit_last);
            end

            fail_count    <= mismatch_total;
            pending_words <= annexb_words.size();
            decoded_bytes <= decoded_total;
            words_checked <= checked_total;
            units_closed  <= closed_total;
            units_dropped <= dropped_total;
        end
    end

endmodule

### tb/sv/tb_length_prefixed_to_annexb_converter.sv
// Top of the converter testbench: clock, reset, stimulus and the verdict.
// Depends on lpab_pkg, the converter and lpab_annexb_checker (scoreboard).
`timescale 1ns / 100ps

module tb_length_prefixed_to_annexb_converter;

    localparam int MAX_LEN_BYTES = 4;
    localparam int PHASES        = 6;
    // decoded bytes per random phase; about 170 input words with the directed units
    localparam int PHASE_BYTES   = 18;

    typedef enum int {
        BREAK_HEADER, BREAK_TRUNCATE, BREAK_ZERO_LEN, BREAK_TAIL, BREAK_NOISE, BREAK_FLIP
    } break_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [lpab_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lpab_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [7:0]                       in_byte;
    logic                             unit_last;
    logic                             out_valid;
    logic                             out_ready;
    logic [7:0]                       out_byte;
    logic                             byte_valid;
    logic                             unit_end;
    logic [1:0]                       status;

    int fail_count;
    int pending_words;
    int decoded_bytes;
    int words_checked;
    int units_closed;
    int units_dropped;

    // register plan for the random phases: in range, then 0 and 7 (clamped)
    logic [lpab_pkg::CFG_DATA_W-1:0] len_plan  [PHASES] =
        '{3'd1, 3'd4, 3'd3, 3'd2, 3'd0, 3'd7};
    logic [lpab_pkg::CFG_DATA_W-1:0] hevc_plan [PHASES] =
        '{3'd0, 3'd7, 3'd1, 3'd0, 3'd1, 3'd0};

    logic [7:0] au[$];      // access unit under construction, one byte per word
    bit         calm;       // no idling on either side (end of run)
    bit         in_quiet;   // no input gaps for the current unit
    int         sent_total;

    length_prefixed_to_annexb_converter #(
        .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .unit_last  (unit_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .unit_end   (unit_end),
        .status     (status)
    );

    lpab_annexb_checker #(
        .MAX_LENGTH_BYTES(MAX_LEN_BYTES)
    ) scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .unit_last     (unit_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .unit_end      (unit_end),
        .status        (status),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .decoded_bytes (decoded_bytes),
        .words_checked (words_checked),
        .units_closed  (units_closed),
        .units_dropped (units_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop. The slowest legal run (every first NAL byte turning into five
    // words, each waiting out the longest output stall) is about a tenth of this.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // Output side backpressure: random stall bursts separated by runs of ready,
    // so stalls land on start code words, body words and status words alike.
    // Ready stays high once the run goes calm.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Both registers written back to back; valid drops only after the second.
    task load_config(input logic [lpab_pkg::CFG_DATA_W-1:0] len_bytes,
                     input logic [lpab_pkg::CFG_DATA_W-1:0] hevc_sel);
        cfg_valid <= 1'b1;
        cfg_index <= lpab_pkg::CFG_NAL_LENGTH_BYTES;
        cfg_data  <= len_bytes;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= lpab_pkg::CFG_CODEC_IS_HEVC;
        cfg_data  <= hevc_sel;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One input word. An optional gap goes in front; valid then holds until
    // the handshake. The caller never lowers valid in the handshake step
    // except through the next gap or the drain.
    task push_byte(input logic [7:0] b, input logic last);
        if (!in_quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        unit_last <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_total++;
    endtask

    task send_unit();
        in_quiet = calm || ($urandom_range(0, 3) == 0);
        foreach (au[i])
            push_byte(au[i], i == au.size() - 1);
    endtask

    // Idle point: stop input, wait for every predicted word, then let the pipeline
    // settle, since a trailing length byte produces no word.
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Well-formed unit of 1..3 NALs with random content; about three in ten
    // get broken afterwards so every status code shows up under each setting.
    task build_unit(input int eff, input bit hevc);
        int         nal_len;
        int         hdr_at;
        int         pick;
        logic [7:0] hdr;
        break_t     how;

        au.delete();
        hdr_at = eff;
        repeat ($urandom_range(1, 3))
        begin
            // mostly short NALs, now and then a longer one
            nal_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14)
                                                  : $urandom_range(1, 5);
            if (hevc && nal_len < 2)
                nal_len = 2;
            for (int i = eff - 1; i >= 0; i--)
                au.push_back(8'(nal_len >> (8 * i)));
            if (hevc)
            begin
                au.push_back({1'b0, 6'($urandom_range(0, 47)), 1'($urandom)});
                au.push_back({5'($urandom), 3'($urandom_range(1, 7))});
                repeat (nal_len - 2) au.push_back(8'($urandom));
            end
            else
            begin
                au.push_back({1'b0, 2'($urandom), 5'($urandom_range(1, 23))});
                repeat (nal_len - 1) au.push_back(8'($urandom));
            end
        end

        if ($urandom_range(0, 9) < 3)
        begin
            how = break_t'($urandom_range(0, 5));
            case (how)
                BREAK_HEADER:
                begin
                    // forbidden bit, type out of range, or HEVC temporal id 0
                    hdr  = au[hdr_at];
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        hdr[7] = 1'b1;
                    else if (hevc && pick == 1)
                        hdr[6:1] = 6'($urandom_range(48, 63));
                    else if (!hevc && pick == 1)
                        hdr[4:0] = 5'd0;
                    else if (!hevc)
                        hdr[4:0] = 5'($urandom_range(24, 31));
                    if (hevc && pick == 2)
                    begin
                        hdr = au[hdr_at + 1];
                        hdr[2:0] = 3'd0;
                        au[hdr_at + 1] = hdr;
                    end
                    else
                    begin
                        au[hdr_at] = hdr;
                    end
                end
                BREAK_TRUNCATE:
                begin
                    // cut short at a random byte: inside or at the end of a length field or a NAL
                    pick = $urandom_range(1, au.size() - 1);
                    while (au.size() > pick) au.pop_back();
                end
                BREAK_ZERO_LEN:
                begin
                    for (int i = 0; i < eff; i++)
                        au[i] = 8'h00;
                end
                BREAK_TAIL:
                begin
                    // stray bytes after the last NAL: partial or complete length
                    repeat ($urandom_range(1, eff)) au.push_back(8'($urandom));
                end
                BREAK_NOISE:
                begin
                    au.delete();
                    repeat ($urandom_range(1, 8)) au.push_back(8'($urandom));
                end
                default:
                begin
                    pick = $urandom_range(0, au.size() - 1);
                    hdr  = au[pick];
                    hdr[$urandom_range(0, 7)] ^= 1'b1;
                    au[pick] = hdr;
                end
            endcase
        end
    endtask

    initial
    begin
        int eff;
        int target;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = lpab_pkg::CFG_NAL_LENGTH_BYTES;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        unit_last  = 1'b0;
        calm       = 1'b0;
        in_quiet   = 1'b0;
        sent_total = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: one-byte length fields, H.264 rules ----
        load_config(3'd1, 3'd0);
        au = '{8'h02, 8'h01, 8'hFF};          // smallest legal type, all-ones body
        send_unit();
        au = '{8'h01, 8'h17};                 // largest legal type, NAL ends the unit
        send_unit();
        au = '{8'h01, 8'h18};                 // type 24 on the last byte
        send_unit();
        au = '{8'h03, 8'h80, 8'h55, 8'hAA};   // forbidden bit, rest dropped
        send_unit();
        au = '{8'h00, 8'h7E};                 // zero length
        send_unit();
        au = '{8'h05, 8'h65, 8'h11};          // NAL runs past unit end
        send_unit();
        au = '{8'h03};                        // length complete on last byte
        send_unit();
        drain();

        // ---- directed: two-byte length fields, HEVC rules ----
        load_config(3'd2, 3'd1);
        au = '{8'h00};                        // length field cut short
        send_unit();
        au = '{8'h00, 8'h02, 8'h40, 8'h01};   // legal two-byte HEVC NAL
        send_unit();
        au = '{8'h00, 8'h01, 8'h40};          // HEVC NAL too short for its header
        send_unit();
        drain();

        // ---- random phases, one register setting each ----
        for (int p = 0; p < PHASES; p++)
        begin
            calm = (p == PHASES - 1);
            load_config(len_plan[p], hevc_plan[p]);
            eff = (len_plan[p] == 0) ? 1 :
                  (len_plan[p] > MAX_LEN_BYTES) ? MAX_LEN_BYTES : int'(len_plan[p]);
            target = decoded_bytes + PHASE_BYTES;
            while (decoded_bytes < target)
            begin
                build_unit(eff, hevc_plan[p][0]);
                send_unit();
            end
            drain();
        end

        $display("sent %0d input bytes (%0d decoded) under %0d register settings",
                 sent_total, decoded_bytes, PHASES + 2);
        $display("checked %0d output words; %0d units closed, %0d dropped on error",
                 words_checked, units_closed, units_dropped);
        if (fail_count == 0 && pending_words == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
hdl/lpab_pkg.sv
hdl/length_prefixed_to_annexb_converter.sv
tb/sv/lpab_annexb_checker.sv
tb/sv/tb_length_prefixed_to_annexb_converter.sv
